// ===== rtl/core/lcg_random_generator_unit_defines.svh =====
// Assertion macros shared by the random generator RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef LCG_RANDOM_GENERATOR_UNIT_DEFINES_SVH
`define LCG_RANDOM_GENERATOR_UNIT_DEFINES_SVH

`ifndef SYNTH
// Check that is switched off while the reset is applied.
`define LRG_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that also holds across the reset.
`define LRG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LRG_ASSERT(lbl, clk, rst_n, prop, msg)
`define LRG_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/core/lcg_rg_pkg.sv =====
// Package of the random generator: action codes, LCG constants, controller
// commands, status and the mixing round table. No dependencies.
package lcg_rg_pkg;

    typedef logic [1:0] t_action;

    localparam t_action ACT_SEED   = 2'd0;
    localparam t_action ACT_DRAW31 = 2'd1;
    localparam t_action ACT_DRAW62 = 2'd2;
    localparam t_action ACT_NOP    = 2'd3;

    localparam logic [31:0] LCG_MUL = 32'd1103515245;
    localparam logic [31:0] LCG_ADD = 32'd12345;

    localparam int MIX_ROUNDS   = 9;
    localparam int LCG_PER_DRAW = 3;
    localparam int STEP_W       = 4;

    typedef logic [STEP_W-1:0] t_step;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    mix_load;
        logic    mix_step;
        t_step   mix_round;
        logic    mix_last;
        logic    lcg_step;
        logic    lcg_first;
        logic    lo_save;
        logic    out_load;
        t_action out_sel;
    } t_dp_cmd;

    // Controller status, watched at the top level.
    typedef struct packed {
        logic busy;
        logic out_full;
    } t_ctrl_status;

    typedef struct packed {
        logic       left;
        logic [4:0] amount;
    } t_mix_shift;

    // Shift of each of the nine mixing rounds.
    function automatic t_mix_shift mix_shift(input t_step round);
        t_mix_shift sh;
        unique case (round)
            4'd0:    sh = '{left: 1'b0, amount: 5'd13};
            4'd1:    sh = '{left: 1'b1, amount: 5'd8};
            4'd2:    sh = '{left: 1'b0, amount: 5'd13};
            4'd3:    sh = '{left: 1'b0, amount: 5'd12};
            4'd4:    sh = '{left: 1'b1, amount: 5'd16};
            4'd5:    sh = '{left: 1'b0, amount: 5'd5};
            4'd6:    sh = '{left: 1'b0, amount: 5'd3};
            4'd7:    sh = '{left: 1'b1, amount: 5'd10};
            4'd8:    sh = '{left: 1'b0, amount: 5'd15};
            default: sh = '{left: 1'b0, amount: 5'd0};
        endcase
        return sh;
    endfunction

endpackage

// ===== rtl/core/lcg_rg_dp.sv =====
// Datapath of the random generator: seed register, mixing round unit,
// LCG step unit, draw accumulator and result register. Uses lcg_rg_pkg.
module lcg_rg_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lcg_rg_pkg::t_dp_cmd i_cmd,
    input  logic [31:0]         i_entropy_a,
    input  logic [31:0]         i_entropy_b,
    input  logic [31:0]         i_entropy_c,
    output logic [61:0]         o_random_value
);
    import lcg_rg_pkg::*;

    logic [31:0] r_seed;
    logic [31:0] r_ma, r_mb, r_mc;
    logic [30:0] r_draw, n_draw;
    logic [30:0] r_lo;
    logic [61:0] r_out, n_out;
    logic [31:0] lcg_next;
    logic [31:0] mix_new;
    logic [31:0] mix_shifted;
    t_mix_shift  sh;

    // One LCG step on the seed through the shared multiplier.
    assign lcg_next = 32'(r_seed * LCG_MUL) + LCG_ADD;

    // One mixing round: x = (x - y - z) ^ shift(z), then the words rotate.
    assign sh          = mix_shift(i_cmd.mix_round);
    assign mix_shifted = sh.left ? (r_mc << sh.amount) : (r_mc >> sh.amount);
    assign mix_new     = (r_ma - r_mb - r_mc) ^ mix_shifted;

    // Extracted bits: eleven on the first step of a draw, ten afterwards.
    always_comb begin
        if (i_cmd.lcg_first) begin
            n_draw = {20'd0, lcg_next[26:16]};
        end else begin
            n_draw = {r_draw[20:0], lcg_next[25:16]};
        end
    end

    // Result selection by action.
    always_comb begin
        unique case (i_cmd.out_sel)
            ACT_SEED:   n_out = {30'd0, r_seed};
            ACT_DRAW31: n_out = {31'd0, r_draw};
            ACT_DRAW62: n_out = {r_draw, r_lo};
            default:    n_out = '0;
        endcase
    end

    // Seed register, the only state whose value carries into later transactions.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= 32'd1;
        end else if (i_cmd.mix_last) begin
            r_seed <= mix_new;
        end else if (i_cmd.lcg_step) begin
            r_seed <= lcg_next;
        end
    end

    // Mixing words.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mix_load) begin
            r_ma <= i_entropy_a;
            r_mb <= i_entropy_b;
            r_mc <= i_entropy_c;
        end else if (i_cmd.mix_step) begin
            r_ma <= r_mb;
            r_mb <= r_mc;
            r_mc <= mix_new;
        end
    end

    // Draw accumulator and the saved low half of a 62-bit value.
    always_ff @(posedge i_clk) begin
        if (i_cmd.lcg_step) begin
            r_draw <= n_draw;
        end
        if (i_cmd.lo_save) begin
            r_lo <= n_draw;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out <= n_out;
        end
    end

    assign o_random_value = r_out;

endmodule

// ===== rtl/core/lcg_rg_ctrl.sv =====
// Controller of the random generator: state machine, round counter and
// output valid flag. Uses lcg_rg_pkg; drives the datapath commands.
module lcg_rg_ctrl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  lcg_rg_pkg::t_action      i_action,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output lcg_rg_pkg::t_dp_cmd      o_cmd,
    output lcg_rg_pkg::t_ctrl_status o_status
);
    import lcg_rg_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MIX  = 2'd1;
    localparam logic [1:0] S_LCG  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] r_state, n_state;
    t_action    r_action, n_action;
    t_step      r_step, n_step;
    logic       r_out_valid, n_out_valid;
    logic       lcg_last;

    // Last LCG step depends on whether one or two values are drawn.
    always_comb begin
        if (r_action == ACT_DRAW62) begin
            lcg_last = (r_step == t_step'(2 * LCG_PER_DRAW - 1));
        end else begin
            lcg_last = (r_step == t_step'(LCG_PER_DRAW - 1));
        end
    end

    // Next state and command decode.
    always_comb begin
        n_state       = r_state;
        n_action      = r_action;
        n_step        = r_step;
        n_out_valid   = r_out_valid;
        o_cmd         = '0;
        o_cmd.out_sel = r_action;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_action       = i_action;
                    n_step         = '0;
                    o_cmd.mix_load = 1'b1;
                    unique case (i_action)
                        ACT_SEED:               n_state = S_MIX;
                        ACT_DRAW31, ACT_DRAW62: n_state = S_LCG;
                        default:                n_state = S_DONE;
                    endcase
                end
            end
            S_MIX: begin
                o_cmd.mix_step  = 1'b1;
                o_cmd.mix_round = r_step;
                if (r_step == t_step'(MIX_ROUNDS - 1)) begin
                    o_cmd.mix_last = 1'b1;
                    n_state        = S_DONE;
                end else begin
                    n_step = r_step + t_step'(1);
                end
            end
            S_LCG: begin
                o_cmd.lcg_step  = 1'b1;
                o_cmd.lcg_first = (r_step == '0) || (r_step == t_step'(LCG_PER_DRAW));
                o_cmd.lo_save   = (r_step == t_step'(LCG_PER_DRAW - 1));
                if (lcg_last) begin
                    n_state = S_DONE;
                end else begin
                    n_step = r_step + t_step'(1);
                end
            end
            S_DONE: begin
                // Load the result once the output register is free.
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_action    <= ACT_NOP;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_action    <= n_action;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall        = (r_state != S_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_status.busy     = (r_state != S_IDLE);
    assign o_status.out_full = r_out_valid;

endmodule

// ===== rtl/core/lcg_random_generator_unit.sv =====
// Random generator with a 32-bit seed: seeding by a 96-bit mix of three
// entropy words, and 31-bit or 62-bit draws from a linear congruential
// generator (multiplier 1103515245, increment 12345), three steps per
// 31-bit value. One transaction is worked on at a time. A seed runs nine
// mixing rounds, one a cycle, a draw runs one LCG step a cycle through a
// single 32x32 multiplier, and an action code of 3 returns zero. The
// result waits in an output register, so the next transaction is accepted
// while it is held; a result only stalls the work when a further result
// is ready before it is taken. The seed is 1 after reset. Uses lcg_rg_pkg,
// lcg_rg_ctrl and lcg_rg_dp.
`include "lcg_random_generator_unit_defines.svh"

module lcg_random_generator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_action,
    input  logic [31:0] i_entropy_a,
    input  logic [31:0] i_entropy_b,
    input  logic [31:0] i_entropy_c,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [61:0] o_random_value
);
    import lcg_rg_pkg::*;

    t_dp_cmd      cmd;
    t_ctrl_status status;

    // Sequencing of the mixing rounds and LCG steps.
    lcg_rg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_action    (i_action),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .o_status    (status)
    );

    // Seed, arithmetic and result register.
    lcg_rg_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_entropy_a    (i_entropy_a),
        .i_entropy_b    (i_entropy_b),
        .i_entropy_c    (i_entropy_c),
        .o_random_value (o_random_value)
    );

    // An accepted transaction keeps the controller busy in the next cycle.
    `LRG_ASSERT(a_accept_busy, i_clk, i_rst_n, (i_in_valid && !o_in_stall) |=> status.busy, "accepted transaction did not start work")

    // Mixing and LCG stepping never share a cycle.
    `LRG_ASSERT(a_cmd_excl, i_clk, i_rst_n, !(cmd.mix_step && cmd.lcg_step), "mix and LCG commands overlap")

    // The result register is only reloaded when its previous result has gone.
    `LRG_ASSERT(a_out_no_overwrite, i_clk, i_rst_n, cmd.out_load |-> (!status.out_full || !i_out_stall), "pending result overwritten")

    // Reset leaves the block idle with no result pending.
    `LRG_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> (!status.busy && !status.out_full), "block not idle after reset")

endmodule

// ===== sim/tb_lcg_random_generator_unit.sv =====
// Self-checking testbench of lcg_random_generator_unit: seeds, no-operation codes, 31-bit and 62-bit draws.
// Uses the package lcg_rg_pkg for the action codes and the generator constants.
// A scoreboard class predicts every result; plain tasks drive both channels.
module tb_lcg_random_generator_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import lcg_rg_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_ITEMS = 2000;
    localparam int PHASE_ITEMS  = 200;
    localparam int TAIL_CYCLES  = 24;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_action;
    logic [31:0] i_entropy_a;
    logic [31:0] i_entropy_b;
    logic [31:0] i_entropy_c;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [61:0] o_random_value;

    // When set, the side concerned does not idle between transactions.
    logic sender_quiet;
    logic receiver_quiet;
    int   idle_cycles;

    // Predicts the value returned for each accepted request and checks it.
    class lcg_value_scoreboard;
        logic [31:0] seed_copy;
        logic [61:0] pending_values[$];
        int          errors;

        function new();
            seed_copy = 32'd1;
            errors    = 0;
        endfunction

        // Jenkins 96-bit mix of the three entropy words.
        function logic [31:0] mix96(logic [31:0] a, logic [31:0] b, logic [31:0] c);
            a = (a - b - c) ^ (c >> 13);
            b = (b - c - a) ^ (a << 8);
            c = (c - a - b) ^ (b >> 13);
            a = (a - b - c) ^ (c >> 12);
            b = (b - c - a) ^ (a << 16);
            c = (c - a - b) ^ (b >> 5);
            a = (a - b - c) ^ (c >> 3);
            b = (b - c - a) ^ (a << 10);
            c = (c - a - b) ^ (b >> 15);
            return c;
        endfunction

        function logic [31:0] lcg_next(logic [31:0] s);
            logic [31:0] product;
            product = s * LCG_MUL;
            return product + LCG_ADD;
        endfunction

        // Three steps: 11 bits from the first, 10 bits from each of the others.
        function logic [30:0] draw_31bit();
            logic [31:0] s;
            logic [30:0] v;
            s = lcg_next(seed_copy);
            v = {20'd0, s[26:16]};
            s = lcg_next(s);
            v = {v[20:0], s[25:16]};
            s = lcg_next(s);
            v = {v[20:0], s[25:16]};
            seed_copy = s;
            return v;
        endfunction

        function void note_request(t_action act, logic [31:0] a, logic [31:0] b,
                                   logic [31:0] c);
            logic [61:0] value;
            logic [30:0] lo;
            logic [30:0] hi;
            value = '0;
            case (act)
                ACT_SEED: begin
                    seed_copy = mix96(a, b, c);
                    value     = {30'd0, seed_copy};
                end
                ACT_DRAW31: begin
                    value = {31'd0, draw_31bit()};
                end
                ACT_DRAW62: begin
                    lo    = draw_31bit();
                    hi    = draw_31bit();
                    value = {hi, lo};
                end
                default: begin
                    // No operation: the seed stays and the result is zero.
                    value = '0;
                end
            endcase
            pending_values.push_back(value);
        endfunction

        function void check_value(logic [61:0] actual);
            logic [61:0] expected;
            if (pending_values.size() == 0) begin
                $error("random_value: result with no transaction waiting, actual %h", actual);
                errors++;
                return;
            end
            expected = pending_values.pop_front();
            if (actual !== expected) begin
                $error("random_value: expected %h, actual %h", expected, actual);
                errors++;
            end
        endfunction

        function int pending();
            return pending_values.size();
        endfunction
    endclass

    lcg_value_scoreboard board;

    lcg_random_generator_unit DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_action       (i_action),
        .i_entropy_a    (i_entropy_a),
        .i_entropy_b    (i_entropy_b),
        .i_entropy_c    (i_entropy_c),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_random_value (o_random_value)
    );

    // Clock with a period of 2 ns.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog: ends the run when no transaction is accepted and no result is taken for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Offers one request after a random gap and holds it until it is accepted.
    task automatic send_request(t_action act, logic [31:0] a, logic [31:0] b,
                                logic [31:0] c);
        int gap;
        gap = sender_quiet ? 0 : $urandom_range(0, 18);
        repeat (gap) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_action    <= act;
        i_entropy_a <= a;
        i_entropy_b <= b;
        i_entropy_c <= c;
        do @(posedge i_clk); while (o_in_stall);
        board.note_request(act, a, b, c);
    endtask

    // Stalls a random number of cycles before each result, then takes it.
    task automatic collect_results();
        int gap;
        forever begin
            gap = receiver_quiet ? 0 : $urandom_range(0, 18);
            repeat (gap) begin
                i_out_stall <= 1'b1;
                @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            board.check_value(o_random_value);
        end
    endtask

    // Holds the request side idle until every predicted value has come back.
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    function automatic logic [31:0] entropy_word();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_action pick_action();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) return ACT_SEED;
        if (r < 55) return ACT_DRAW31;
        if (r < 90) return ACT_DRAW62;
        return ACT_NOP;
    endfunction

    initial begin
        int mode;
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_action       <= ACT_NOP;
        i_entropy_a    <= '0;
        i_entropy_b    <= '0;
        i_entropy_c    <= '0;
        i_out_stall    <= 1'b0;
        sender_quiet   = 1'b0;
        receiver_quiet = 1'b0;
        board          = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        fork
            collect_results();
        join_none

        // Directed part: draws from the reset seed, extreme entropy, no-operation
        // code, and entropy words that a draw must ignore.
        send_request(ACT_DRAW31, 32'h0, 32'h0, 32'h0);
        send_request(ACT_DRAW62, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(ACT_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(ACT_DRAW31, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F);
        send_request(ACT_SEED, 32'h0, 32'h0, 32'h0);
        send_request(ACT_DRAW31, 32'h0, 32'h0, 32'h0);
        send_request(ACT_SEED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(ACT_DRAW62, 32'h0, 32'h0, 32'h0);
        send_request(ACT_DRAW62, 32'h0, 32'h0, 32'h0);
        send_request(ACT_SEED, 32'hFFFF_FFFF, 32'h0, 32'h0);
        send_request(ACT_SEED, 32'h0, 32'hFFFF_FFFF, 32'h0);
        send_request(ACT_SEED, 32'h0, 32'h0, 32'hFFFF_FFFF);
        send_request(ACT_DRAW31, 32'h0, 32'h0, 32'h0);
        send_request(ACT_NOP, 32'h0, 32'h0, 32'h0);
        send_request(ACT_DRAW31, 32'h0, 32'h0, 32'h0);
        send_request(ACT_SEED, 32'h8000_0000, 32'h0000_0001, 32'h7FFF_FFFF);
        send_request(ACT_DRAW62, $urandom, $urandom, $urandom);
        send_request(ACT_NOP, $urandom, $urandom, $urandom);
        send_request(ACT_DRAW31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        wait_for_results();

        // Random part in phases, each with its own idling pattern.
        for (int p = 0; p < RANDOM_ITEMS / PHASE_ITEMS; p++) begin
            mode           = (p < 4) ? p : $urandom_range(0, 3);
            sender_quiet   = mode[0];
            receiver_quiet = mode[1];
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_request(pick_action(), entropy_word(), entropy_word(), entropy_word());
            end
            if (p == 4) begin
                wait_for_results();
            end
        end

        // Drain the remaining results and let the block settle.
        sender_quiet   = 1'b0;
        receiver_quiet = 1'b0;
        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
